### rtl/core/ffba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared codes and types for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int FIELD_W = 12;

  localparam logic [1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [1:0] FUNC_FREE    = 2'd1;
  localparam logic [1:0] FUNC_REALLOC = 2'd2;
  localparam logic [1:0] FUNC_NOP     = 2'd3;

  // Verdict on one header of the chain walk
  typedef struct packed {
    logic is_end;  // stored length is zero
    logic room;    // tail space from current header holds the request
    logic split;   // free block, remainder holds a header
    logic whole;   // free block, fits but cannot be split
    logic over;    // stepping past this block leaves the arena
  } ffba_fit_t;

endpackage

`default_nettype wire

### rtl/core/ffba_fit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_fit
// Judges one header of the first-fit walk and computes the next header.
// ----------------------------------------------------------------------------
module ffba_fit #(
  parameter int ARENA_BYTES  = 4096,
  parameter int HEADER_BYTES = 8,
  parameter int LW           = 13,
  parameter int CW           = 14
) (
  input  wire logic [LW-1:0]          len,
  input  wire logic                   taken,
  input  wire logic [CW-1:0]          cur,
  input  wire logic [CW-1:0]          need,
  output ffba_pkg::ffba_fit_t         fit,
  output logic      [CW-1:0]          next_cur
);
  import ffba_pkg::*;

  localparam logic [CW-1:0] ARENA_C = CW'(ARENA_BYTES);
  localparam logic [CW-1:0] HDR_C   = CW'(HEADER_BYTES);

  logic [CW-1:0] len_w;

  always_comb begin
    len_w        = CW'(len);
    next_cur     = cur + len_w;
    fit.is_end   = (len == '0);
    fit.room     = ((ARENA_C - cur) >= need);
    fit.split    = !fit.is_end && !taken && (len_w >= need + HDR_C);
    fit.whole    = !fit.is_end && !taken && !fit.split && (len_w >= need);
    fit.over     = !fit.is_end && !fit.split && !fit.whole && (next_cur >= ARENA_C);
  end

endmodule

`default_nettype wire

### rtl/core/first_fit_block_allocator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit
// First-fit allocator over a chain of headed blocks kept in on-chip metadata.
// ----------------------------------------------------------------------------
// Reset: a clearing pass zeroes the metadata memory; no input transfer is
//   taken until it ends.
// Steps: free or fitting realloc checks the header; allocate walks headers,
//   one per cycle at the memory read port; realloc grows in place by absorbing
//   free successors, else moves with a walk; a split writes the remainder header.
// Throughput: one item in flight; next transfer once the result is registered.
module first_fit_block_allocator_unit #(
  parameter int ARENA_BYTES  = 4096,
  parameter int HEADER_BYTES = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_func,
  input  wire logic [ffba_pkg::FIELD_W-1:0]  in_request_bytes,
  input  wire logic                          in_has_pointer,
  input  wire logic [ffba_pkg::FIELD_W-1:0]  in_block_offset,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_success,
  output logic      [ffba_pkg::FIELD_W-1:0]  out_result_offset,
  output logic                               out_copy_needed,
  output logic      [ffba_pkg::FIELD_W-1:0]  out_copy_bytes
);
  import ffba_pkg::*;

  localparam int AW = $clog2(ARENA_BYTES);
  localparam int LW = $clog2(ARENA_BYTES + 1);
  localparam int CW = ((AW > FIELD_W) ? AW : FIELD_W) + 2;
  localparam int EW = LW + 1;

  localparam logic [CW-1:0] ARENA_C = CW'(ARENA_BYTES);
  localparam logic [CW-1:0] HDR_C   = CW'(HEADER_BYTES);
  localparam logic [AW-1:0] LAST_A  = AW'(ARENA_BYTES - 1);

  localparam logic [3:0] ST_CLR    = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_CHK    = 4'd2;
  localparam logic [3:0] ST_ABS    = 4'd3;
  localparam logic [3:0] ST_LAUNCH = 4'd4;
  localparam logic [3:0] ST_WALK   = 4'd5;
  localparam logic [3:0] ST_SPLIT  = 4'd6;
  localparam logic [3:0] ST_RESP   = 4'd7;

  // Metadata memory: {taken, length} per byte offset of a header
  logic [EW-1:0] meta_mem [ARENA_BYTES];
  logic [EW-1:0] rd_q;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  logic [3:0]          state_r, state_nxt;
  logic [AW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic [1:0]          func_r, func_nxt;
  logic [FIELD_W-1:0]  req_r, req_nxt;
  logic [FIELD_W-1:0]  boff_r, boff_nxt;
  logic [AW-1:0]       hdr_r, hdr_nxt;
  logic [CW-1:0]       cur_r, cur_nxt;
  logic [CW-1:0]       need_r, need_nxt;
  logic [CW-1:0]       nxt_r, nxt_nxt;
  logic [LW-1:0]       acc_r, acc_nxt;
  logic [LW-1:0]       old_len_r, old_len_nxt;
  logic                old_taken_r, old_taken_nxt;
  logic                move_r, move_nxt;
  logic [AW-1:0]       split_addr_r, split_addr_nxt;
  logic [LW-1:0]       split_len_r, split_len_nxt;
  logic                res_success_r, res_success_nxt;
  logic [FIELD_W-1:0]  res_offset_r, res_offset_nxt;
  logic                res_copy_r, res_copy_nxt;
  logic [FIELD_W-1:0]  res_copy_bytes_r, res_copy_bytes_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_success_r, out_success_nxt;
  logic [FIELD_W-1:0]  out_offset_r, out_offset_nxt;
  logic                out_copy_r, out_copy_nxt;
  logic [FIELD_W-1:0]  out_copy_bytes_r, out_copy_bytes_nxt;

  logic [LW-1:0] rd_len;
  logic          rd_taken;
  logic [CW-1:0] in_hdr_w;
  logic          in_ptr_ok;
  logic [CW-1:0] split_at;
  logic          absorb;
  ffba_fit_t     fit;
  logic [CW-1:0] walk_next;

  assign rd_len   = rd_q[LW-1:0];
  assign rd_taken = rd_q[LW];

  // Synchronous memory, one write and one read port, registered read data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      meta_mem[wr_addr] <= wr_data;
    end
    rd_q <= meta_mem[rd_addr];
  end

  ffba_fit #(
    .ARENA_BYTES  (ARENA_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .LW           (LW),
    .CW           (CW)
  ) u_fit (
    .len      (rd_len),
    .taken    (rd_taken),
    .cur      (cur_r),
    .need     (need_r),
    .fit      (fit),
    .next_cur (walk_next)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign in_hdr_w = CW'(in_block_offset) - HDR_C;
  assign in_ptr_ok = in_has_pointer && (CW'(in_block_offset) >= HDR_C) && (in_hdr_w < ARENA_C);
  assign split_at = cur_r + need_r;
  assign absorb   = (nxt_r < ARENA_C) && (rd_len != '0) && !rd_taken;

  always_comb begin
    state_nxt          = state_r;
    clr_cnt_nxt        = clr_cnt_r;
    func_nxt           = func_r;
    req_nxt            = req_r;
    boff_nxt           = boff_r;
    hdr_nxt            = hdr_r;
    cur_nxt            = cur_r;
    need_nxt           = need_r;
    nxt_nxt            = nxt_r;
    acc_nxt            = acc_r;
    old_len_nxt        = old_len_r;
    old_taken_nxt      = old_taken_r;
    move_nxt           = move_r;
    split_addr_nxt     = split_addr_r;
    split_len_nxt      = split_len_r;
    res_success_nxt    = res_success_r;
    res_offset_nxt     = res_offset_r;
    res_copy_nxt       = res_copy_r;
    res_copy_bytes_nxt = res_copy_bytes_r;
    out_valid_nxt      = out_valid_r && !out_ready;
    out_success_nxt    = out_success_r;
    out_offset_nxt     = out_offset_r;
    out_copy_nxt       = out_copy_r;
    out_copy_bytes_nxt = out_copy_bytes_r;
    rd_addr            = cur_r[AW-1:0];
    wr_en              = 1'b0;
    wr_addr            = hdr_r;
    wr_data            = '0;

    unique case (state_r)
      ST_CLR: begin
        // Sweep the metadata memory to zero, one entry a cycle
        wr_en       = 1'b1;
        wr_addr     = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_A) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          func_nxt           = in_func;
          req_nxt            = in_request_bytes;
          boff_nxt           = in_block_offset;
          hdr_nxt            = in_hdr_w[AW-1:0];
          need_nxt           = CW'(in_request_bytes) + HDR_C;
          move_nxt           = 1'b0;
          res_success_nxt    = 1'b0;
          res_offset_nxt     = '0;
          res_copy_nxt       = 1'b0;
          res_copy_bytes_nxt = '0;
          priority if (in_func == FUNC_ALLOC ||
                       (in_func == FUNC_REALLOC && !in_has_pointer)) begin
            // Start the walk at the arena base
            cur_nxt   = '0;
            rd_addr   = '0;
            state_nxt = ST_WALK;
          end else if ((in_func == FUNC_FREE || in_func == FUNC_REALLOC) && in_ptr_ok) begin
            rd_addr   = in_hdr_w[AW-1:0];
            state_nxt = ST_CHK;
          end else begin
            // Null or out-of-range pointer, or no operation: empty result
            state_nxt = ST_RESP;
          end
        end
      end

      ST_CHK: begin
        if (CW'(rd_len) < HDR_C) begin
          state_nxt = ST_RESP;
        end else if (func_r == FUNC_FREE) begin
          wr_en     = 1'b1;
          wr_data   = {1'b0, rd_len};
          state_nxt = ST_RESP;
        end else begin
          old_len_nxt   = rd_len;
          old_taken_nxt = rd_taken;
          if (CW'(rd_len) - HDR_C >= CW'(req_r)) begin
            // Block already big enough: keep it
            res_success_nxt = 1'b1;
            res_offset_nxt  = boff_r;
            state_nxt       = ST_RESP;
          end else begin
            acc_nxt   = rd_len;
            nxt_nxt   = CW'(hdr_r) + CW'(rd_len);
            rd_addr   = nxt_nxt[AW-1:0];
            state_nxt = ST_ABS;
          end
        end
      end

      ST_ABS: begin
        if (absorb) begin
          // Swallow a free successor and read the one after it
          acc_nxt = acc_r + rd_len;
          nxt_nxt = nxt_r + CW'(rd_len);
          rd_addr = nxt_nxt[AW-1:0];
        end else if (CW'(acc_r) - HDR_C >= CW'(req_r)) begin
          wr_en           = 1'b1;
          wr_data         = {old_taken_r, acc_r};
          res_success_nxt = 1'b1;
          res_offset_nxt  = boff_r;
          state_nxt       = ST_RESP;
        end else begin
          // Release the grown block and search for a new home
          wr_en     = 1'b1;
          wr_data   = {1'b0, acc_r};
          move_nxt  = 1'b1;
          cur_nxt   = '0;
          state_nxt = ST_LAUNCH;
        end
      end

      ST_LAUNCH: begin
        // Read of the base is issued here so it sees the write-back above
        rd_addr   = '0;
        state_nxt = ST_WALK;
      end

      ST_WALK: begin
        if (fit.split || fit.whole || (fit.is_end && fit.room)) begin
          wr_en           = 1'b1;
          wr_addr         = cur_r[AW-1:0];
          wr_data         = fit.whole ? {1'b1, rd_len} : {1'b1, need_r[LW-1:0]};
          res_success_nxt = 1'b1;
          res_offset_nxt  = FIELD_W'(cur_r + HDR_C);
          if (move_r) begin
            res_copy_nxt       = 1'b1;
            res_copy_bytes_nxt = FIELD_W'(CW'(old_len_r) - HDR_C);
          end
          split_addr_nxt = split_at[AW-1:0];
          split_len_nxt  = rd_len - need_r[LW-1:0];
          state_nxt      = (fit.split && split_at < ARENA_C) ? ST_SPLIT : ST_RESP;
        end else if (fit.is_end || fit.over) begin
          // No room: a failed move takes the old block back
          if (move_r) begin
            wr_en   = 1'b1;
            wr_data = {1'b1, acc_r};
          end
          state_nxt = ST_RESP;
        end else begin
          cur_nxt = walk_next;
          rd_addr = walk_next[AW-1:0];
        end
      end

      ST_SPLIT: begin
        wr_en     = 1'b1;
        wr_addr   = split_addr_r;
        wr_data   = {1'b0, split_len_r};
        state_nxt = ST_RESP;
      end

      ST_RESP: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt      = 1'b1;
          out_success_nxt    = res_success_r;
          out_offset_nxt     = res_offset_r;
          out_copy_nxt       = res_copy_r;
          out_copy_bytes_nxt = res_copy_bytes_r;
          state_nxt          = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r           <= func_nxt;
    req_r            <= req_nxt;
    boff_r           <= boff_nxt;
    hdr_r            <= hdr_nxt;
    cur_r            <= cur_nxt;
    need_r           <= need_nxt;
    nxt_r            <= nxt_nxt;
    acc_r            <= acc_nxt;
    old_len_r        <= old_len_nxt;
    old_taken_r      <= old_taken_nxt;
    move_r           <= move_nxt;
    split_addr_r     <= split_addr_nxt;
    split_len_r      <= split_len_nxt;
    res_success_r    <= res_success_nxt;
    res_offset_r     <= res_offset_nxt;
    res_copy_r       <= res_copy_nxt;
    res_copy_bytes_r <= res_copy_bytes_nxt;
    out_success_r    <= out_success_nxt;
    out_offset_r     <= out_offset_nxt;
    out_copy_r       <= out_copy_nxt;
    out_copy_bytes_r <= out_copy_bytes_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_success       = out_success_r;
  assign out_result_offset = out_offset_r;
  assign out_copy_needed   = out_copy_r;
  assign out_copy_bytes    = out_copy_bytes_r;

  // A transfer always starts work
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != ST_IDLE)
    else $error("accepted item left the sequencer idle");

  // The walk never looks at a header outside the arena
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |-> cur_r < ARENA_C)
    else $error("walk pointer beyond arena");

  // A copy is only requested with a granted block
  a_copy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_success || !out_copy_needed))
    else $error("copy requested without a block");

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the first-fit block allocator. A shadow copy of the
// block-length and taken metadata predicts every grant; directed rows cover
// bad pointers, full arena, split, whole take, in-place growth and moves,
// then a long run of mostly well-formed alloc/free/realloc traffic follows
// under changing sender and receiver idling.
// ----------------------------------------------------------------------------
module tb;
  import ffba_pkg::*;

  localparam int ARENA = 4096;
  localparam int HDR = 8;
  localparam int RANDOM_ITEMS = 1625;
  localparam int HOLD_AT_ITEM = 60;
  localparam int HOLD_CYCLES = 500;
  // Longest walk plus absorb plus moving walk, rounded up.
  localparam int DRAIN_CYCLES = 1100;
  localparam int CYCLE_LIMIT = 6_000_000;
  localparam bit TYPED = 1'b1;
  localparam bit PREDICTED = 1'b0;

  typedef struct packed {
    logic               success;
    logic [FIELD_W-1:0] offset;
    logic               copy;
    logic [FIELD_W-1:0] copy_bytes;
  } grant_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [FIELD_W-1:0] req;
    logic               has_ptr;
    logic [FIELD_W-1:0] boff;
    bit                 typed;
    grant_t             want;
  } stim_row_t;

  localparam grant_t NO_GRANT = '0;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_func = FUNC_NOP;
  logic [FIELD_W-1:0] in_request_bytes = '0;
  logic               in_has_pointer = 1'b0;
  logic [FIELD_W-1:0] in_block_offset = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_success;
  logic [FIELD_W-1:0] out_result_offset;
  logic               out_copy_needed;
  logic [FIELD_W-1:0] out_copy_bytes;

  // Shadow metadata, indexed by header byte offset
  logic [12:0] shadow_len [ARENA];
  logic        shadow_taken [ARENA];

  grant_t             pending_grants [$];
  logic [FIELD_W-1:0] held_blocks [$];
  stim_row_t          directed_rows [$];

  int  mismatches = 0;
  int  items_sent = 0;
  int  cycle_count = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  logic hold_off = 1'b0;

  first_fit_block_allocator_unit #(
    .ARENA_BYTES  (ARENA),
    .HEADER_BYTES (HDR)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_request_bytes  (in_request_bytes),
    .in_has_pointer    (in_has_pointer),
    .in_block_offset   (in_block_offset),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_success       (out_success),
    .out_result_offset (out_result_offset),
    .out_copy_needed   (out_copy_needed),
    .out_copy_bytes    (out_copy_bytes)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Walk the shadow chain from offset 0 and claim the first free block that
  // fits; split it when the rest holds a header, else take it whole; with no fit, append at the tail.
  function automatic bit claim_first_fit(input int unsigned req,
                                         output int unsigned payload);
    int unsigned cur;
    int unsigned need;
    int unsigned len;
    cur = 0;
    need = req + HDR;
    payload = 0;
    while (cur < ARENA && shadow_len[cur] != 0) begin
      len = shadow_len[cur];
      if (!shadow_taken[cur] && len >= need + HDR) begin
        if (cur + need < ARENA) begin
          shadow_len[cur + need] = 13'(len - need);
          shadow_taken[cur + need] = 1'b0;
        end
        shadow_taken[cur] = 1'b1;
        shadow_len[cur] = 13'(need);
        payload = cur + HDR;
        return 1'b1;
      end
      if (!shadow_taken[cur] && len >= need) begin
        shadow_taken[cur] = 1'b1;
        payload = cur + HDR;
        return 1'b1;
      end
      cur += len;
    end
    if (cur < ARENA && ARENA - cur >= need) begin
      shadow_taken[cur] = 1'b1;
      shadow_len[cur] = 13'(need);
      payload = cur + HDR;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Apply one operation to the shadow metadata and return its grant.
  function automatic grant_t predict_grant(input logic [1:0] func,
                                           input logic [FIELD_W-1:0] req,
                                           input logic has_ptr,
                                           input logic [FIELD_W-1:0] boff);
    grant_t      g;
    int unsigned hdr;
    int unsigned old_len;
    int unsigned len;
    int unsigned nxt;
    int unsigned p;
    bit          ptr_ok;
    g = NO_GRANT;
    hdr = 0;
    ptr_ok = 1'b0;
    if (has_ptr && boff >= HDR) begin
      hdr = boff - HDR;
      ptr_ok = hdr < ARENA && shadow_len[hdr] >= HDR;
    end
    if (func == FUNC_ALLOC || (func == FUNC_REALLOC && !has_ptr)) begin
      if (claim_first_fit(req, p)) begin
        g.success = 1'b1;
        g.offset = p[FIELD_W-1:0];
      end
    end else if (func == FUNC_FREE) begin
      if (ptr_ok) shadow_taken[hdr] = 1'b0;
    end else if (func == FUNC_REALLOC && ptr_ok) begin
      old_len = shadow_len[hdr];
      len = old_len;
      if (len - HDR >= req) begin
        g.success = 1'b1;
        g.offset = boff;
      end else begin
        // Absorb free successors; keep the grown length even if too short.
        nxt = hdr + len;
        while (nxt < ARENA && shadow_len[nxt] != 0 && !shadow_taken[nxt]) begin
          len += shadow_len[nxt];
          nxt += shadow_len[nxt];
        end
        shadow_len[hdr] = 13'(len);
        if (len - HDR >= req) begin
          g.success = 1'b1;
          g.offset = boff;
        end else begin
          shadow_taken[hdr] = 1'b0;
          if (claim_first_fit(req, p)) begin
            g.success = 1'b1;
            g.offset = p[FIELD_W-1:0];
            g.copy = 1'b1;
            g.copy_bytes = 12'(old_len - HDR);
          end else begin
            shadow_taken[hdr] = 1'b1;
          end
        end
      end
    end
    return g;
  endfunction

  function automatic void drop_block(input logic [FIELD_W-1:0] off);
    for (int i = held_blocks.size() - 1; i >= 0; i--) begin
      if (held_blocks[i] == off) held_blocks.delete(i);
    end
  endfunction

  // Mostly small payloads keep the chain short; a few reach the extremes.
  function automatic logic [FIELD_W-1:0] draw_size();
    int roll;
    roll = $urandom_range(99);
    if (roll < 85) return FIELD_W'($urandom_range(48));
    if (roll < 97) return FIELD_W'($urandom_range(400, 49));
    return FIELD_W'($urandom_range(4095, 401));
  endfunction

  // Offer one item, hold it until the transfer, then predict and record it.
  task automatic send_item(input stim_row_t row);
    grant_t g;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= row.func;
    in_request_bytes <= row.req;
    in_has_pointer <= row.has_ptr;
    in_block_offset <= row.boff;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    g = predict_grant(row.func, row.req, row.has_ptr, row.boff);
    // Track live payload pointers so later frees and reallocs hit them.
    if (row.func == FUNC_FREE && row.has_ptr) drop_block(row.boff);
    if (g.copy) drop_block(row.boff);
    if (g.success && (g.copy || row.func == FUNC_ALLOC || !row.has_ptr))
      held_blocks.push_back(g.offset);
    pending_grants.push_back(row.typed ? row.want : g);
    items_sent++;
  endtask

  // Receiver: check each result transfer, then choose next cycle's ready.
  always @(posedge clk) begin
    grant_t got;
    grant_t exp_g;
    if (out_valid && out_ready) begin
      got = {out_success, out_result_offset, out_copy_needed, out_copy_bytes};
      if (pending_grants.size() == 0) begin
        $display("%0t: unexpected grant ok=%0d off=%0d cp=%0d n=%0d", $time,
                 got.success, got.offset, got.copy, got.copy_bytes);
        mismatches++;
      end else begin
        exp_g = pending_grants.pop_front();
        if (got.success !== exp_g.success || got.offset !== exp_g.offset ||
            got.copy !== exp_g.copy || got.copy_bytes !== exp_g.copy_bytes) begin
          $display("%0t: grant mismatch: exp ok=%0d off=%0d cp=%0d n=%0d, got ok=%0d off=%0d cp=%0d n=%0d",
                   $time, exp_g.success, exp_g.offset, exp_g.copy, exp_g.copy_bytes,
                   got.success, got.offset, got.copy, got.copy_bytes);
          mismatches++;
        end
      end
    end
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Long receiver hold-off: the sender keeps offering, so the block stalls
  // its input with a finished grant parked in the output register.
  initial begin
    wait (items_sent >= HOLD_AT_ITEM);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached", $time);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    stim_row_t          row;
    logic [1:0]         f;
    logic [FIELD_W-1:0] rq;
    logic               hp;
    logic [FIELD_W-1:0] bo;
    int                 roll;
    int                 pick;

    for (int i = 0; i < ARENA; i++) begin
      shadow_len[i] = '0;
      shadow_taken[i] = 1'b0;
    end

    // Directed table: func, request, has_pointer, offset, typed, grant.
    // Typed grants are the obvious ones; the rest come from the shadow.
    // No operation, null frees and bad pointers give an all-zero grant.
    directed_rows.push_back({FUNC_NOP, 12'd4095, 1'b1, 12'd4095, TYPED, NO_GRANT});
    directed_rows.push_back({FUNC_FREE, 12'd0, 1'b0, 12'd0, TYPED, NO_GRANT});
    directed_rows.push_back({FUNC_FREE, 12'd0, 1'b1, 12'd0, TYPED, NO_GRANT});
    // Offset below a header, then a header with zero length
    directed_rows.push_back({FUNC_REALLOC, 12'd100, 1'b1, 12'd4, TYPED, NO_GRANT});
    directed_rows.push_back({FUNC_REALLOC, 12'd100, 1'b1, 12'd8, TYPED, NO_GRANT});
    // Largest request cannot fit; the next takes the whole arena
    directed_rows.push_back({FUNC_ALLOC, 12'd4095, 1'b0, 12'd0, TYPED, NO_GRANT});
    directed_rows.push_back({FUNC_ALLOC, 12'd4088, 1'b0, 12'd0, TYPED,
                             grant_t'({1'b1, 12'd8, 1'b0, 12'd0})});
    directed_rows.push_back({FUNC_ALLOC, 12'd0, 1'b0, 12'd0, TYPED, NO_GRANT});
    // Block already big enough: keep it
    directed_rows.push_back({FUNC_REALLOC, 12'd4088, 1'b1, 12'd8, TYPED,
                             grant_t'({1'b1, 12'd8, 1'b0, 12'd0})});
    directed_rows.push_back({FUNC_FREE, 12'd0, 1'b1, 12'd8, TYPED, NO_GRANT});
    // Split the freed arena twice, then a request that fits nowhere
    directed_rows.push_back({FUNC_ALLOC, 12'd0, 1'b0, 12'd0, PREDICTED, NO_GRANT});
    directed_rows.push_back({FUNC_ALLOC, 12'd100, 1'b0, 12'd0, PREDICTED, NO_GRANT});
    directed_rows.push_back({FUNC_ALLOC, 12'd4000, 1'b0, 12'd0, PREDICTED, NO_GRANT});
    directed_rows.push_back({FUNC_REALLOC, 12'd50, 1'b1, 12'd16, PREDICTED, NO_GRANT});
    directed_rows.push_back({FUNC_FREE, 12'd0, 1'b1, 12'd8, PREDICTED, NO_GRANT});
    // Grow in place by absorbing the free tail
    directed_rows.push_back({FUNC_REALLOC, 12'd200, 1'b1, 12'd16, PREDICTED, NO_GRANT});
    // Take a minimal block whole; null realloc acts as allocate
    directed_rows.push_back({FUNC_ALLOC, 12'd0, 1'b0, 12'd0, PREDICTED, NO_GRANT});
    directed_rows.push_back({FUNC_REALLOC, 12'd20, 1'b0, 12'd0, PREDICTED, NO_GRANT});
    directed_rows.push_back({FUNC_FREE, 12'd0, 1'b1, 12'd16, PREDICTED, NO_GRANT});
    directed_rows.push_back({FUNC_ALLOC, 12'd10, 1'b0, 12'd0, PREDICTED, NO_GRANT});
    directed_rows.push_back({FUNC_ALLOC, 12'd20, 1'b0, 12'd0, PREDICTED, NO_GRANT});
    // Taken successor blocks growth: move with copy
    directed_rows.push_back({FUNC_REALLOC, 12'd3000, 1'b1, 12'd16, PREDICTED, NO_GRANT});
    // Absorb, still short, no room to move: old block stays taken
    directed_rows.push_back({FUNC_REALLOC, 12'd4095, 1'b1, 12'd62, PREDICTED, NO_GRANT});
    directed_rows.push_back({FUNC_REALLOC, 12'd0, 1'b1, 12'd4095, TYPED, NO_GRANT});
    directed_rows.push_back({FUNC_ALLOC, 12'd0, 1'b1, 12'd4095, PREDICTED, NO_GRANT});

    // Hold reset, then release it; the block then clears its metadata itself.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) send_item(directed_rows[i]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Idling phases: none, sender idle, receiver stall, both light.
      if (n < 375) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end else if (n < 775) begin
        send_idle_pct = 77;
        recv_stall_pct = 0;
      end else if (n < 1175) begin
        send_idle_pct = 0;
        recv_stall_pct = 77;
      end else begin
        send_idle_pct = 12;
        recv_stall_pct = 12;
      end

      // Pointer bits ride along on every item, even where ignored.
      f = FUNC_ALLOC;
      rq = draw_size();
      hp = 1'b0;
      bo = FIELD_W'($urandom_range(4095));
      roll = $urandom_range(99);
      if (roll < 36) begin
        hp = 1'($urandom_range(1));
      end else if (roll < 62 && held_blocks.size() > 0) begin
        pick = $urandom_range(held_blocks.size() - 1);
        f = FUNC_FREE;
        hp = 1'b1;
        bo = held_blocks[pick];
      end else if (roll < 86 && held_blocks.size() > 0) begin
        pick = $urandom_range(held_blocks.size() - 1);
        f = FUNC_REALLOC;
        hp = 1'b1;
        bo = held_blocks[pick];
      end else begin
        // Noise: no-ops, stray pointers, null reallocs, huge requests.
        rq = FIELD_W'($urandom_range(4095));
        hp = 1'($urandom_range(1));
        case ($urandom_range(3))
          0: f = FUNC_NOP;
          1: f = $urandom_range(1) ? FUNC_FREE : FUNC_REALLOC;
          2: begin
            f = FUNC_REALLOC;
            hp = 1'b0;
            rq = draw_size();
          end
          default: f = FUNC_ALLOC;
        endcase
      end
      row = {f, rq, hp, bo, PREDICTED, NO_GRANT};
      send_item(row);
    end
    in_valid <= 1'b0;

    // Drain: wait for every grant, then watch for strays.
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
